### hdl/ilu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilu_pkg
// Shared constants and types for the indexed list insert/delete unit.
// ----------------------------------------------------------------------------
package ilu_pkg;

  // list capacity and derived widths
  localparam int DEPTH  = 64;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int WORD_W = 32;
  localparam int OP_W   = 3;
  localparam int IDX_IN_W = 8;
  localparam int CNT_OUT_W = 7;

  // read-back reduction groups
  localparam int GRP  = 8;
  localparam int NGRP = (DEPTH + GRP - 1) / GRP;

  // operation codes
  localparam logic [OP_W-1:0] OP_GET       = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD_HEAD  = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD_TAIL  = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD_INDEX = 3'd3;
  localparam logic [OP_W-1:0] OP_DELETE    = 3'd4;

  // command broadcast to every cell
  typedef struct packed {
    logic              en;
    logic              ins;
    logic              del;
    logic              get;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  count;
    logic [WORD_W-1:0] value;
  } ilu_cmd_t;

endpackage
`default_nettype wire

### hdl/ilu_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ilu_cell
// One list slot: holds an entry, shifts from its neighbors on insert or
// delete, and captures its entry for a get that hits its slot.
// ----------------------------------------------------------------------------
module ilu_cell (
  input  wire                          clk,
  input  ilu_pkg::ilu_cmd_t            cmd,
  input  wire [ilu_pkg::CMP_W-1:0]     slot,
  input  wire [ilu_pkg::WORD_W-1:0]    left_in,
  input  wire [ilu_pkg::WORD_W-1:0]    right_in,
  output logic [ilu_pkg::WORD_W-1:0]   data,
  output logic [ilu_pkg::WORD_W-1:0]   sel
);
  import ilu_pkg::*;

  logic [WORD_W-1:0] data_next;
  logic [WORD_W-1:0] sel_next;

  // slot update and read capture
  always_comb begin
    data_next = data;
    sel_next  = '0;
    if (cmd.ins) begin
      if (slot == cmd.pos) begin
        data_next = cmd.value;
      end else if (slot > cmd.pos && slot <= cmd.count) begin
        data_next = left_in;
      end
    end
    if (cmd.del) begin
      if (slot >= cmd.pos && (slot + CMP_W'(1)) < cmd.count) begin
        data_next = right_in;
      end
    end
    if (cmd.get && slot == cmd.pos) begin
      sel_next = data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.en) begin
      data <= data_next;
      sel  <= sel_next;
    end
  end

endmodule
`default_nettype wire

### hdl/indexed_list_insert_delete_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit
// Ordered list of signed words with get, insert and delete by position.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries op, index and value. Output
//   channel (out_valid/out_stall) carries one result item per input item:
//   read_value, found, accepted, full_drop and entry_count.
//   The list lives in a row of cells, one per position. On the accepting
//   edge every affected cell updates at once, shifting from its left or
//   right neighbor or taking the new value, so insert and delete finish
//   in that cycle. A get is captured by the hit cell, then OR-reduced
//   through a registered group stage. For every item, out_valid rises
//   only after the group stage and then read_value have been registered.
//   One item at a time: no new item is accepted until the result of the
//   last one is taken, so each stalled output cycle delays acceptance.
//   in_stall is high during reset and from acceptance until the result
//   is taken.
//   Reset clears the count to zero (empty list) and the control state;
//   entry contents are only read below the count.
//   While out_stall is high the result holds and no new item is taken.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_unit (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_valid,
  output logic                           in_stall,
  input  wire [ilu_pkg::OP_W-1:0]        op,
  input  wire [ilu_pkg::IDX_IN_W-1:0]    index,
  input  wire signed [ilu_pkg::WORD_W-1:0] value,
  output logic                           out_valid,
  input  wire                            out_stall,
  output logic signed [ilu_pkg::WORD_W-1:0] read_value,
  output logic                           found,
  output logic                           accepted,
  output logic                           full_drop,
  output logic [ilu_pkg::CNT_OUT_W-1:0]  entry_count
);
  import ilu_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]        state;
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              take;
  ilu_cmd_t          cmd;

  logic [CMP_W-1:0]  idx_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic [CMP_W-1:0]  ins_pos;
  logic              is_ins;
  logic              ins_ok;
  logic              is_full;
  logic              del_ok;
  logic              get_hit;
  logic              acc_now;
  logic              drop_now;

  logic [WORD_W-1:0] cell_data [DEPTH];
  logic [WORD_W-1:0] cell_sel  [DEPTH];
  logic [WORD_W-1:0] grp_or    [NGRP];
  logic [WORD_W-1:0] grp_or_next [NGRP];
  logic [WORD_W-1:0] all_or;

  // operation decode
  assign take    = in_valid && !in_stall;
  assign idx_ext = CMP_W'(index);
  assign cnt_ext = CMP_W'(count);
  assign is_full = (cnt_ext == CMP_W'(DEPTH));

  always_comb begin
    is_ins  = 1'b0;
    ins_pos = '0;
    unique case (op)
      OP_ADD_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      OP_ADD_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = cnt_ext;
      end
      OP_ADD_INDEX: begin
        is_ins  = 1'b1;
        ins_pos = idx_ext;
      end
      default: begin
        is_ins  = 1'b0;
        ins_pos = '0;
      end
    endcase
  end

  assign ins_ok   = is_ins && (ins_pos <= cnt_ext);
  assign del_ok   = (op == OP_DELETE) && (idx_ext < cnt_ext);
  assign get_hit  = (op == OP_GET) && (idx_ext < cnt_ext);
  assign acc_now  = (ins_ok && !is_full) || del_ok;
  assign drop_now = ins_ok && is_full;

  always_comb begin
    count_next = count;
    if (ins_ok && !is_full) begin
      count_next = count + CNT_W'(1);
    end else if (del_ok) begin
      count_next = count - CNT_W'(1);
    end
  end

  // command broadcast to the cell row
  always_comb begin
    cmd.en    = take;
    cmd.ins   = take && ins_ok && !is_full;
    cmd.del   = take && del_ok;
    cmd.get   = take && get_hit;
    cmd.pos   = is_ins ? ins_pos : idx_ext;
    cmd.count = cnt_ext;
    cmd.value = value;
  end

  // row of cells
  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic [WORD_W-1:0] left_w;
      logic [WORD_W-1:0] right_w;
      if (gi == 0) begin : g_first
        assign left_w = '0;
      end else begin : g_mid_l
        assign left_w = cell_data[gi-1];
      end
      if (gi == DEPTH - 1) begin : g_last
        assign right_w = '0;
      end else begin : g_mid_r
        assign right_w = cell_data[gi+1];
      end
      ilu_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .slot     (CMP_W'(gi)),
        .left_in  (left_w),
        .right_in (right_w),
        .data     (cell_data[gi]),
        .sel      (cell_sel[gi])
      );
    end
  endgenerate

  // group reduction of captured words
  always_comb begin
    for (int j = 0; j < NGRP; j++) begin
      grp_or_next[j] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (j * GRP + k < DEPTH) begin
          grp_or_next[j] = grp_or_next[j] | cell_sel[j * GRP + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RED) begin
      for (int j = 0; j < NGRP; j++) begin
        grp_or[j] <= grp_or_next[j];
      end
    end
  end

  always_comb begin
    all_or = '0;
    for (int j = 0; j < NGRP; j++) begin
      all_or = all_or | grp_or[j];
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      found     <= get_hit;
      accepted  <= acc_now;
      full_drop <= drop_now;
    end
    if (state == S_FIN) begin
      read_value <= found ? all_or : '1;
    end
  end

  // sequencer and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (take) begin
            state <= S_RED;
            count <= count_next;
          end
        end
        S_RED: begin
          state <= S_FIN;
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall    = rst || (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign entry_count = CNT_OUT_W'(count);

endmodule
`default_nettype wire

### tb/indexed_list_insert_delete_unit_test.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_unit_test
// Self-checking bench for the indexed list insert/delete unit.
// A shadow list in the bench tracks every accepted item and queues the
// result item it should produce. A checker compares each delivered result
// field by field. The stimulus covers empty-list corner cases, every
// operation, a full list with dropped inserts, a long receiver hold-off and
// a long random run. Sender gaps and receiver stalls vary throughout.
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_unit_test;
  import ilu_pkg::*;

  // op codes the block treats as no-ops
  localparam logic [OP_W-1:0] OP_RSVD_FIRST = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_LAST  = 3'd7;

  localparam logic signed [WORD_W-1:0] WORD_MIN  = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0] WORD_MAX  = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] WORD_NONE = -32'sd1;

  localparam int HOLD_CYCLES = 300;
  localparam int RANDOM_ITEMS = 640;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic                     found;
    logic                     accepted;
    logic                     full_drop;
    logic [CNT_OUT_W-1:0]     entry_count;
  } list_result_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [OP_W-1:0]             op = '0;
  logic [IDX_IN_W-1:0]         index = '0;
  logic signed [WORD_W-1:0]    value = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic signed [WORD_W-1:0]    read_value;
  logic                        found;
  logic                        accepted;
  logic                        full_drop;
  logic [CNT_OUT_W-1:0]        entry_count;

  // shadow copy of the list and the results it owes
  logic signed [WORD_W-1:0]    shadow_words [DEPTH];
  int                          shadow_len = 0;
  list_result_t                results_due [$];
  int                          errors = 0;

  // sender burst state and receiver hold-off request
  int                          burst_left = 0;
  bit                          hold_request = 1'b0;

  indexed_list_insert_delete_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .index       (index),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_value  (read_value),
    .found       (found),
    .accepted    (accepted),
    .full_drop   (full_drop),
    .entry_count (entry_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("[indexed_list_insert_delete_unit] ERROR");
    $finish;
  end

  // apply one accepted item to the shadow list and queue its result
  task automatic apply_list_op(input logic [OP_W-1:0] o, input logic [IDX_IN_W-1:0] idx,
                               input logic signed [WORD_W-1:0] v);
    list_result_t r;
    int pos;
    r.read_value = WORD_NONE;
    r.found      = 1'b0;
    r.accepted   = 1'b0;
    r.full_drop  = 1'b0;
    case (o)
      OP_GET: begin
        if (int'(idx) < shadow_len) begin
          r.read_value = shadow_words[idx];
          r.found      = 1'b1;
        end
      end
      OP_ADD_HEAD, OP_ADD_TAIL, OP_ADD_INDEX: begin
        pos = (o == OP_ADD_HEAD) ? 0 : (o == OP_ADD_TAIL) ? shadow_len : int'(idx);
        if (pos <= shadow_len) begin
          if (shadow_len >= DEPTH) begin
            r.full_drop = 1'b1;
          end else begin
            for (int i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
            shadow_words[pos] = v;
            shadow_len++;
            r.accepted = 1'b1;
          end
        end
      end
      OP_DELETE: begin
        if (int'(idx) < shadow_len) begin
          for (int i = int'(idx); i + 1 < shadow_len; i++) shadow_words[i] = shadow_words[i+1];
          shadow_len--;
          r.accepted = 1'b1;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_OUT_W'(shadow_len);
    results_due.push_back(r);
  endtask

  // predict on every accepted input item
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) apply_list_op(op, index, value);
  end

  // compare every delivered result with the oldest prediction
  always @(posedge clk) begin : check_result
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("result item with none pending: read_value %0d entry_count %0d",
               read_value, entry_count);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (read_value !== want.read_value) begin
          $error("read_value: expected %0d, got %0d", want.read_value, read_value);
          errors++;
        end
        if (found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, found);
          errors++;
        end
        if (accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, accepted);
          errors++;
        end
        if (full_drop !== want.full_drop) begin
          $error("full_drop: expected %0d, got %0d", want.full_drop, full_drop);
          errors++;
        end
        if (entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
          errors++;
        end
      end
    end
  end

  // receiver: changing stall modes, run length capped, plus long hold-off
  always @(posedge clk) begin : receiver
    int mode;
    int mode_left;
    int stall_run;
    int hold_left;
    int cyc;
    bit stall;
    cyc++;
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      stall = 1'b1;
    end else begin
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (mode)
        0: stall = 1'b0;
        1: stall = ($urandom_range(0, 3) == 0);
        2: stall = ((cyc % 7) < 3);
        default: stall = ($urandom_range(0, 3) != 0);
      endcase
      if (stall_run >= 8) stall = 1'b0;
    end
    stall_run = stall ? stall_run + 1 : 0;
    out_stall <= stall;
  end

  // offer one item and hold it until taken, then maybe pause
  task automatic send_item(input logic [OP_W-1:0] o, input logic [IDX_IN_W-1:0] idx,
                           input logic signed [WORD_W-1:0] v);
    int gap;
    in_valid <= 1'b1;
    op       <= o;
    index    <= idx;
    value    <= v;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 12);
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic sender_idle();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering, then wait until every owed result has been delivered
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  // mostly a legal position, sometimes anywhere in the index range
  function automatic logic [IDX_IN_W-1:0] pick_index(input int limit);
    if (limit < 0) limit = 0;
    if (limit > 255) limit = 255;
    if ($urandom_range(0, 99) < 85) return IDX_IN_W'($urandom_range(0, limit));
    return IDX_IN_W'($urandom_range(0, 255));
  endfunction

  function automatic logic signed [WORD_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return WORD_MIN;
      1: return WORD_MAX;
      2: return '0;
      3: return WORD_NONE;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_add_op();
    case ($urandom_range(0, 2))
      0: return OP_ADD_HEAD;
      1: return OP_ADD_TAIL;
      default: return OP_ADD_INDEX;
    endcase
  endfunction

  function automatic logic [OP_W-1:0] OP_LIST_RSVD();
    return OP_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
  endfunction

  // empty list: misses, ignored ops, last-entry delete and tail reuse
  task automatic test_empty_list();
    send_item(OP_GET, 8'd0, pick_value());
    send_item(OP_GET, 8'd255, pick_value());
    send_item(OP_DELETE, 8'd0, pick_value());
    send_item(OP_ADD_INDEX, 8'd1, 32'sd5);
    send_item(OP_RSVD_FIRST, 8'd0, pick_value());
    send_item(OP_ADD_INDEX, 8'd0, WORD_MAX);
    send_item(OP_GET, 8'd0, pick_value());
    send_item(OP_DELETE, 8'd0, pick_value());
    send_item(OP_ADD_TAIL, 8'd17, WORD_MIN);
    send_item(OP_ADD_HEAD, 8'd200, 32'sd7);
    send_item(OP_GET, 8'd1, pick_value());
    send_item(OP_GET, 8'd0, pick_value());
  endtask

  // each op in the middle and at the ends of a short list
  task automatic test_each_op();
    send_item(OP_ADD_INDEX, 8'd1, 32'sh5555_5555);
    send_item(OP_ADD_INDEX, 8'd3, 32'shaaaa_aaaa);
    send_item(OP_ADD_INDEX, 8'd255, 32'sd9);
    send_item(OP_GET, 8'd3, pick_value());
    send_item(OP_GET, 8'd2, pick_value());
    send_item(OP_DELETE, 8'd1, pick_value());
    send_item(OP_DELETE, 8'd255, pick_value());
    send_item(OP_GET, 8'd4, pick_value());
    send_item(OP_RSVD_FIRST + 3'd1, 8'd0, pick_value());
    send_item(OP_RSVD_LAST, 8'd255, WORD_NONE);
    send_item(OP_ADD_TAIL, 8'd0, WORD_NONE);
    send_item(OP_GET, 8'd3, pick_value());
  endtask

  // fill to capacity, try every insert on a full list, then empty it
  task automatic test_full_list();
    int len;
    wait_results_drained();
    len = shadow_len;
    while (len < DEPTH) begin
      send_item(pick_add_op(), IDX_IN_W'($urandom_range(0, len)), pick_value());
      len++;
    end
    send_item(OP_ADD_HEAD, 8'd0, pick_value());
    send_item(OP_ADD_TAIL, 8'd0, pick_value());
    send_item(OP_ADD_INDEX, 8'd0, pick_value());
    send_item(OP_ADD_INDEX, IDX_IN_W'(DEPTH), pick_value());
    send_item(OP_ADD_INDEX, IDX_IN_W'(DEPTH + 1), pick_value());
    send_item(OP_GET, IDX_IN_W'(DEPTH - 1), pick_value());
    send_item(OP_GET, IDX_IN_W'(DEPTH), pick_value());
    send_item(OP_DELETE, IDX_IN_W'(DEPTH - 1), pick_value());
    send_item(OP_ADD_INDEX, IDX_IN_W'(DEPTH - 1), pick_value());
    send_item(OP_DELETE, 8'd0, pick_value());
    send_item(OP_ADD_HEAD, 8'd0, pick_value());
    wait_results_drained();
    len = shadow_len;
    while (len > 0) begin
      send_item(OP_DELETE, IDX_IN_W'($urandom_range(0, len - 1)), pick_value());
      len--;
    end
    send_item(OP_GET, 8'd0, pick_value());
    send_item(OP_ADD_TAIL, 8'd0, pick_value());
  endtask

  // receiver holds off for a long stretch while items keep coming
  task automatic test_receiver_holdoff();
    hold_request = 1'b1;
    burst_left   = 20;
    repeat (8) send_item(pick_add_op(), pick_index(shadow_len), pick_value());
  endtask

  // random ops, drifting between growing and shrinking the list
  task automatic test_random_ops(input int n);
    bit grow;
    int r;
    logic [OP_W-1:0] o;
    grow = 1'b0;
    for (int k = 0; k < n; k++) begin
      if (k % 120 == 0) grow = !grow;
      r = $urandom_range(0, 99);
      if (r < 3) o = OP_LIST_RSVD();
      else if (r < 20) o = OP_GET;
      else if ($urandom_range(0, 99) < (grow ? 70 : 30)) o = pick_add_op();
      else o = OP_DELETE;
      send_item(o, pick_index((o == OP_ADD_INDEX) ? shadow_len : shadow_len - 1),
                pick_value());
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_list();
    test_each_op();
    test_full_list();
    test_receiver_holdoff();
    test_random_ops(RANDOM_ITEMS);
    sender_idle();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("[indexed_list_insert_delete_unit] OK");
    end else begin
      $display("[indexed_list_insert_delete_unit] ERROR");
    end
    $finish;
  end

endmodule
